// ===== rtl/core/kce_pkg.sv =====
package kce_pkg;

  localparam int MAX_SET_SIZE  = 64;
  localparam int MAX_COMB_SIZE = 8;
  localparam int VALUE_WIDTH   = 8;

  localparam int POS_W  = $clog2(MAX_SET_SIZE);
  localparam int N_W    = $clog2(MAX_SET_SIZE + 1);
  localparam int PTR_W  = (MAX_COMB_SIZE > 1) ? $clog2(MAX_COMB_SIZE) : 1;
  localparam int K_W    = 4;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_SIZE  = 2'd0,
    CFG_COMB_SIZE = 2'd1
  } cfg_reg_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_NEXT    = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_MEMBER    = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_SIZE_ERR  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEND,
    S_SCAN,
    S_FILL
  } state_e;

endpackage

// ===== rtl/core/k_combination_enumerator.sv =====
// Lexicographic k-combination generator over a 64-entry element store. Load and restart
// transactions produce nothing. A next transaction emits k member results, each a
// store read followed by the output register, then does the advance: the shared
// compare examines the indices in turn while scanning from the right, then the indices
// from the advancing one onward are refilled in turn. Status results (exhausted, size
// error) go straight to the output register. The input is not ready until a next
// transaction has finished its advance; output stalls hold the sequence in S_SEND.
module k_combination_enumerator import kce_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       command_i,
  input  logic [POS_W-1:0]       load_position_i,
  input  logic [VALUE_WIDTH-1:0] load_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STAT_W-1:0]      status_o,
  output logic [POS_W-1:0]       element_index_o,
  output logic [VALUE_WIDTH-1:0] element_value_o,
  output logic                   last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  state_e                 state_q, state_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic [POS_W-1:0]       nv_q, nv_d;
  logic                   exh_q, exh_d;
  logic [N_W-1:0]         set_size_q;
  logic [K_W-1:0]         comb_size_q;
  logic [POS_W-1:0]       idx_q [MAX_COMB_SIZE];
  logic [VALUE_WIDTH-1:0] mem_q [MAX_SET_SIZE];
  logic [VALUE_WIDTH-1:0] rd_q;

  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [POS_W-1:0]       out_index_q, out_index_d;
  logic                   out_last_q, out_last_d;

  logic                   idx_restart, idx_we;
  logic                   in_acc;
  logic [N_W-1:0]         n_eff;
  logic [PTR_W:0]         k_eff;
  logic [PTR_W-1:0]       k_last;
  logic [N_W-1:0]         maxv;
  logic [POS_W-1:0]       cur_idx;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;

  // Clamp configuration to the supported range
  always_comb begin
    n_eff = (set_size_q > N_W'(MAX_SET_SIZE)) ? N_W'(MAX_SET_SIZE) : set_size_q;
    if (comb_size_q == '0) begin
      k_eff = (PTR_W+1)'(1);
    end else if ({1'b0, comb_size_q} > 5'(MAX_COMB_SIZE)) begin
      k_eff = (PTR_W+1)'(MAX_COMB_SIZE);
    end else begin
      k_eff = (PTR_W+1)'(comb_size_q);
    end
  end

  assign k_last  = PTR_W'(k_eff - 1'b1);
  assign cur_idx = idx_q[ptr_q];
  // Maximum for index position ptr: n - k + ptr (never negative once k <= n)
  assign maxv    = n_eff - N_W'(k_eff) + N_W'(ptr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q  <= N_W'(52);
      comb_size_q <= K_W'(5);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SET_SIZE:  set_size_q  <= cfg_data_i;
        CFG_COMB_SIZE: comb_size_q <= cfg_data_i[K_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && command_i == CMD_LOAD) begin
      mem_q[load_position_i] <= load_value_i;
    end
    rd_q <= mem_q[cur_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_COMB_SIZE; i++) begin
        idx_q[i] <= POS_W'(i % MAX_SET_SIZE);
      end
    end else if (idx_restart) begin
      for (int i = 0; i < MAX_COMB_SIZE; i++) begin
        idx_q[i] <= POS_W'(i % MAX_SET_SIZE);
      end
    end else if (idx_we) begin
      idx_q[ptr_q] <= nv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      exh_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      exh_q       <= exh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nv_q         <= nv_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    nv_d         = nv_q;
    exh_d        = exh_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_last_d   = out_last_q;
    idx_restart  = 1'b0;
    idx_we       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (command_i)
            CMD_RESTART: begin
              idx_restart = 1'b1;
              exh_d       = 1'b0;
            end
            CMD_NEXT: begin
              if (N_W'(k_eff) > n_eff || exh_q) begin
                out_valid_d  = 1'b1;
                out_status_d = (N_W'(k_eff) > n_eff) ? ST_SIZE_ERR : ST_EXHAUSTED;
                out_index_d  = '0;
                out_last_d   = 1'b1;
                state_d      = S_SEND;
              end else begin
                ptr_d   = '0;
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // rd_q picks up the element this cycle and holds while ptr is still
        out_valid_d  = 1'b1;
        out_status_d = ST_MEMBER;
        out_index_d  = cur_idx;
        out_last_d   = (ptr_q == k_last);
        state_d      = S_SEND;
      end
      S_SEND: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_status_q != ST_MEMBER) begin
            state_d = S_IDLE;
          end else if (out_last_q) begin
            ptr_d   = k_last;
            state_d = S_SCAN;
          end else begin
            ptr_d   = ptr_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_SCAN: begin
        if (N_W'(cur_idx) < maxv) begin
          nv_d    = cur_idx + 1'b1;
          state_d = S_FILL;
        end else if (ptr_q == '0) begin
          exh_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end
      S_FILL: begin
        idx_we = 1'b1;
        nv_d   = nv_q + 1'b1;
        if (ptr_q == k_last) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign element_index_o = out_index_q;
  assign element_value_o = (out_status_q == ST_MEMBER) ? rd_q : '0;
  assign last_o          = out_last_q;

  a_busy_while_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result is pending");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_MEMBER) |-> last_o)
    else $error("status result not marked last");

  a_more_members: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> (state_q == S_READ))
    else $error("member sequence cut short");

  a_scan_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o && status_o == ST_MEMBER)
      |=> (state_q == S_SCAN && ptr_q == k_last))
    else $error("advance did not start at the rightmost index");

endmodule
